[rtl/bet_pkg.sv]
// Package: shared constants, types and op codes for the breakpoint envelope table.
`timescale 1ns / 1ps
package bet_pkg;
   localparam int MAX_POINTS_DEF = 64;
   localparam int TIME_BITS_DEF  = 24;
   localparam int VALUE_BITS_DEF = 24;
   localparam int OP_BITS        = 3;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_BITS     = 7;
   localparam int CSR_BITS       = 24;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_VALUE  = 3'd2,
      OP_NEAR   = 3'd3,
      OP_AFTER  = 3'd4,
      OP_BEFORE = 3'd5,
      OP_BAD6   = 3'd6,
      OP_BAD7   = 3'd7
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_COMPACT, S_CW, S_POS, S_PW, S_SHIFT, S_SW, S_PUT,
      S_SCAN, S_SCW, S_FETCH, S_FW, S_DIV, S_DONE
   } state_type;
endpackage

[rtl/bet_front.sv]
// Front end: two-entry command queue towards the engine.
`timescale 1ns / 1ps
module bet_front #(
   parameter int TIME_BITS  = bet_pkg::TIME_BITS_DEF,
   parameter int VALUE_BITS = bet_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [bet_pkg::OP_BITS-1:0]    op_i,
   input  logic [TIME_BITS-1:0]           t_i,
   input  logic [TIME_BITS-1:0]           hi_i,
   input  logic signed [VALUE_BITS-1:0]   v_i,
   output logic                           cmd_valid,
   input  logic                           cmd_take,
   output bet_pkg::op_type                cmd_op,
   output logic [TIME_BITS-1:0]           cmd_t,
   output logic [TIME_BITS-1:0]           cmd_hi,
   output logic signed [VALUE_BITS-1:0]   cmd_v
);
   import bet_pkg::*;
   localparam int W = OP_BITS + 2*TIME_BITS + VALUE_BITS;
   logic [W-1:0] q_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         wr, rd;
   logic [OP_BITS-1:0] head_op;

   assign full = (cnt_ff == 2'd2);
   assign wr = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign rd = cmd_take && cmd_valid;
   assign {head_op, cmd_t, cmd_hi, cmd_v} = q_ff[rp_ff];
   assign cmd_op = op_type'(head_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) q_ff[wp_ff] <= {op_i, t_i, hi_i, v_i};
   end

   a_noover: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("command queue count out of range");
   a_noread: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !rd) else $error("read of empty command queue");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      wr && !rd |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("queue count slip");
endmodule

[rtl/bet_engine.sv]
// Back end: table memory, sequenced edit/search passes and a serial divider.
`timescale 1ns / 1ps
module bet_engine #(
   parameter int MAX_POINTS = bet_pkg::MAX_POINTS_DEF,
   parameter int TIME_BITS  = bet_pkg::TIME_BITS_DEF,
   parameter int VALUE_BITS = bet_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bet_pkg::CSR_BITS-1:0]   min_step,
   input  logic                           cmd_valid,
   output logic                           cmd_take,
   input  bet_pkg::op_type                cmd_op,
   input  logic [TIME_BITS-1:0]           cmd_t,
   input  logic [TIME_BITS-1:0]           cmd_hi,
   input  logic signed [VALUE_BITS-1:0]   cmd_v,
   output logic                           res_valid,
   input  logic                           res_ready,
   output logic [bet_pkg::STATUS_BITS-1:0] res_status,
   output logic [TIME_BITS-1:0]           res_time,
   output logic signed [VALUE_BITS-1:0]   res_value,
   output logic [bet_pkg::COUNT_BITS-1:0] res_count
);
   import bet_pkg::*;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = VALUE_BITS + 1;
   localparam int DCW = $clog2(DW + 1);
   localparam int RW = TIME_BITS + 1;

   logic [TIME_BITS-1:0]  tmem [MAX_POINTS];
   logic [VALUE_BITS-1:0] vmem [MAX_POINTS];

   state_type            st_ff, st_in;
   op_type               op_ff;
   logic [TIME_BITS-1:0] t_ff, hi_ff;
   logic signed [VALUE_BITS-1:0] v_ff;
   logic [CW-1:0]        cnt_ff, i_ff, k_ff;
   logic [AW-1:0]        ra, wa;
   logic                 we;
   logic [TIME_BITS-1:0] wt, rt_ff;
   logic [VALUE_BITS-1:0] wv, rv_ff;
   // search results
   logic                 fa_ff, fb_ff;
   logic [AW-1:0]        ia_ff, ib_ff, in_ff;
   logic [TIME_BITS-1:0] bd_ff;
   logic                 ph_ff;  // fetch phase: 0 before point, 1 after point
   logic [TIME_BITS-1:0] lt_ff;
   logic signed [VALUE_BITS-1:0] lv_ff;
   // divider
   logic [DW-1:0]        mag_ff, q_ff;
   logic [TIME_BITS:0]   r_ff;
   logic [TIME_BITS-1:0] num_ff, den_ff;
   logic [DCW-1:0]       dc_ff;
   logic                 neg_ff;
   logic [TIME_BITS+1:0] div_r2;
   // result register
   logic                 rvld_ff;
   logic [STATUS_BITS-1:0] rs_ff;
   logic [TIME_BITS-1:0] rtm_ff;
   logic [VALUE_BITS-1:0] rvl_ff;

   logic [TIME_BITS-1:0] gap;
   logic                 drop;
   logic                 iend;

   assign res_valid = rvld_ff;
   assign res_status = rs_ff;
   assign res_time = rtm_ff;
   assign res_value = rvl_ff;
   assign res_count = COUNT_BITS'(cnt_ff);
   assign cmd_take = (st_ff == S_IDLE) && !rvld_ff;
   assign iend = (i_ff == cnt_ff);

   assign gap = (rt_ff > t_ff) ? rt_ff - t_ff : t_ff - rt_ff;
   assign drop = (op_ff == OP_INSERT) ? (gap < TIME_BITS'(min_step))
                 : (rt_ff > t_ff && rt_ff < hi_ff);

   // r < den, so 2r + num < 3*den: a quotient digit of up to two per step
   assign div_r2 = {r_ff, 1'b0} + (mag_ff[DW-1] ? {2'b0, num_ff} : '0);

   always_ff @(posedge clock) begin
      if (we) begin
         tmem[wa] <= wt;
         vmem[wa] <= wv;
      end
      rt_ff <= tmem[ra];
      rv_ff <= vmem[ra];
   end

   always_comb begin
      st_in = st_ff; ra = i_ff[AW-1:0]; we = 1'b0; wa = k_ff[AW-1:0];
      wt = rt_ff; wv = rv_ff;
      unique case (st_ff)
         S_IDLE: if (cmd_valid && !rvld_ff) begin
            unique case (cmd_op)
               OP_INSERT, OP_REMOVE: st_in = S_COMPACT;
               OP_VALUE, OP_NEAR, OP_AFTER, OP_BEFORE: st_in = S_SCAN;
               default: st_in = S_DONE;
            endcase
         end
         S_COMPACT: st_in = iend ? (op_ff == OP_INSERT ? S_POS : S_DONE) : S_CW;
         S_CW: begin
            we = !drop; st_in = S_COMPACT;
         end
         S_POS: begin
            if (cnt_ff == CW'(MAX_POINTS)) st_in = S_DONE;
            else st_in = iend ? S_SHIFT : S_PW;
         end
         S_PW: st_in = (rt_ff <= t_ff) ? S_POS : S_SHIFT;
         S_SHIFT: begin
            ra = AW'(k_ff - CW'(1));
            st_in = (k_ff == i_ff) ? S_PUT : S_SW;
         end
         S_SW: begin
            we = 1'b1; st_in = S_SHIFT;
         end
         S_PUT: begin
            we = 1'b1; wt = t_ff; wv = v_ff; st_in = S_DONE;
         end
         S_SCAN: st_in = iend ? S_FETCH : S_SCW;
         S_SCW: st_in = S_SCAN;
         S_FETCH: begin
            ra = (op_ff == OP_NEAR) ? in_ff :
                 (op_ff == OP_AFTER) ? ia_ff :
                 (op_ff == OP_BEFORE) ? ib_ff : (ph_ff ? ia_ff : ib_ff);
            st_in = S_FW;
         end
         S_FW: begin
            if (op_ff == OP_VALUE && !ph_ff && fa_ff && fb_ff) st_in = S_FETCH;
            else if (op_ff == OP_VALUE && ph_ff) st_in = S_DIV;
            else st_in = S_DONE;
         end
         S_DIV: st_in = (dc_ff == DCW'(0)) ? S_DONE : S_DIV;
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; rvld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (rvld_ff && res_ready) rvld_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (cmd_valid && !rvld_ff) begin
               op_ff <= cmd_op; t_ff <= cmd_t; hi_ff <= cmd_hi; v_ff <= cmd_v;
               i_ff <= '0; k_ff <= '0; fa_ff <= 1'b0; fb_ff <= 1'b0;
               ph_ff <= 1'b0; rtm_ff <= '0; rvl_ff <= '0;
               rs_ff <= (cmd_op inside {OP_INSERT, OP_REMOVE, OP_VALUE, OP_NEAR,
                                        OP_AFTER, OP_BEFORE}) ? ST_OK : ST_NONE;
            end
            S_COMPACT: begin
               if (iend) begin
                  cnt_ff <= k_ff; i_ff <= '0;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_CW: if (!drop) k_ff <= k_ff + CW'(1);
            S_POS: begin
               k_ff <= cnt_ff;
               if (cnt_ff == CW'(MAX_POINTS)) rs_ff <= ST_FULL;
               else if (!iend) i_ff <= i_ff + CW'(1);
            end
            S_PW: if (rt_ff > t_ff) i_ff <= i_ff - CW'(1);
            S_SW: k_ff <= k_ff - CW'(1);
            S_PUT: cnt_ff <= cnt_ff + CW'(1);
            S_SCAN: i_ff <= i_ff + CW'(1);
            S_SCW: begin
               if (rt_ff > t_ff && !fa_ff) begin
                  fa_ff <= 1'b1; ia_ff <= AW'(i_ff - CW'(1));
               end
               if (rt_ff < t_ff) begin
                  fb_ff <= 1'b1; ib_ff <= AW'(i_ff - CW'(1));
               end
               if (i_ff == CW'(1) || gap < bd_ff) begin
                  bd_ff <= gap; in_ff <= AW'(i_ff - CW'(1));
               end
            end
            S_FW: begin
               unique case (op_ff)
                  OP_NEAR:
                     if (cnt_ff == '0) rs_ff <= ST_NONE;
                     else begin rtm_ff <= rt_ff; rvl_ff <= rv_ff; end
                  OP_AFTER:
                     if (!fa_ff) rs_ff <= ST_NONE;
                     else begin rtm_ff <= rt_ff; rvl_ff <= rv_ff; end
                  OP_BEFORE:
                     if (!fb_ff) rs_ff <= ST_NONE;
                     else begin rtm_ff <= rt_ff; rvl_ff <= rv_ff; end
                  default:
                     if (!(fa_ff && fb_ff)) rs_ff <= ST_NONE;
                     else if (!ph_ff) begin
                        ph_ff <= 1'b1; lt_ff <= rt_ff; lv_ff <= rv_ff;
                     end else begin
                        neg_ff <= ($signed(rv_ff) < lv_ff);
                        mag_ff <= ($signed(rv_ff) < lv_ff)
                           ? DW'({lv_ff[VALUE_BITS-1], lv_ff})
                             - DW'({rv_ff[VALUE_BITS-1], rv_ff})
                           : DW'({rv_ff[VALUE_BITS-1], rv_ff})
                             - DW'({lv_ff[VALUE_BITS-1], lv_ff});
                        num_ff <= t_ff - lt_ff;
                        den_ff <= rt_ff - lt_ff;
                        q_ff <= '0; r_ff <= '0; dc_ff <= DCW'(DW);
                     end
               endcase
            end
            S_DIV: if (dc_ff != DCW'(0)) begin
               // one quotient digit (0, 1 or 2) per cycle
               if (div_r2 >= {1'b0, den_ff, 1'b0}) begin
                  r_ff <= RW'(div_r2 - {1'b0, den_ff, 1'b0});
                  q_ff <= {q_ff[DW-2:0], 1'b0} + DW'(2);
               end else if (div_r2 >= {2'b0, den_ff}) begin
                  r_ff <= RW'(div_r2 - {2'b0, den_ff});
                  q_ff <= {q_ff[DW-2:0], 1'b1};
               end else begin
                  r_ff <= RW'(div_r2);
                  q_ff <= {q_ff[DW-2:0], 1'b0};
               end
               mag_ff <= {mag_ff[DW-2:0], 1'b0};
               dc_ff <= dc_ff - DCW'(1);
            end else begin
               rvl_ff <= VALUE_BITS'(neg_ff ? lv_ff - VALUE_BITS'(q_ff)
                                            : lv_ff + VALUE_BITS'(q_ff));
            end
            S_DONE: rvld_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS)) else $error("count above table size");
   a_take: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> !rvld_ff) else $error("command taken over waiting result");
   a_full: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_PUT |-> cnt_ff < CW'(MAX_POINTS)) else $error("insert into full table");
endmodule

[rtl/breakpoint_envelope_table_top.sv]
// Top level of the breakpoint envelope table.
`timescale 1ns / 1ps
// Usage:
//  Requests enter as a queue: drive req_* and push; a transfer happens when
//  push is high and full is low. A two-entry command queue decouples intake
//  from the table engine, so requests can be queued while one is worked on.
//  Results leave as a queue: while empty is low rsp_* hold the oldest result;
//  pop with empty low completes the transfer. One result per request.
//  Sequence: an edit compacts the table point by point, and an insert then
//  finds its slot and shifts the later points; a search scans the table and
//  fetches the chosen point; interpolation adds a second fetch and a pass
//  through the bit-serial divider.
//  The point table is one memory with one write and one read port; that port
//  and the sequencer over it set the rate, one item at a time.
//  Reset (synchronous, high) empties the table and clears min_time_step; the
//  stored points themselves are not cleared.
//  If the receiver stalls, the finished result waits in its register, the
//  engine holds, and full rises once the command queue has two entries.
//  csr_we writes min_time_step at once; write it only while idle.
module breakpoint_envelope_table_top #(
   parameter int MAX_POINTS = bet_pkg::MAX_POINTS_DEF,
   parameter int TIME_BITS  = bet_pkg::TIME_BITS_DEF,
   parameter int VALUE_BITS = bet_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [bet_pkg::OP_BITS-1:0]     req_op,
   input  logic [TIME_BITS-1:0]            req_time_req,
   input  logic [TIME_BITS-1:0]            req_upper_time,
   input  logic signed [VALUE_BITS-1:0]    req_value,
   output logic                            empty,
   input  logic                            pop,
   output logic [bet_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [TIME_BITS-1:0]            rsp_point_time,
   output logic signed [VALUE_BITS-1:0]    rsp_point_value,
   output logic [bet_pkg::COUNT_BITS-1:0]  rsp_point_count,
   input  logic                            csr_we,
   input  logic [bet_pkg::CSR_BITS-1:0]    csr_wdata
);
   import bet_pkg::*;
   logic [CSR_BITS-1:0]          step_ff;
   logic                         cv, ct, rv;
   op_type                       cop;
   logic [TIME_BITS-1:0]         ctm, chi;
   logic signed [VALUE_BITS-1:0] cval;

   // spacing register
   always_ff @(posedge clock) begin
      if (reset) step_ff <= '0;
      else if (csr_we) step_ff <= csr_wdata;
   end

   bet_front #(.TIME_BITS(TIME_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
      .clock, .reset, .push, .full,
      .op_i(req_op), .t_i(req_time_req), .hi_i(req_upper_time), .v_i(req_value),
      .cmd_valid(cv), .cmd_take(ct), .cmd_op(cop), .cmd_t(ctm), .cmd_hi(chi),
      .cmd_v(cval));

   bet_engine #(.MAX_POINTS(MAX_POINTS), .TIME_BITS(TIME_BITS),
                .VALUE_BITS(VALUE_BITS)) u_engine (
      .clock, .reset, .min_step(step_ff),
      .cmd_valid(cv), .cmd_take(ct), .cmd_op(cop), .cmd_t(ctm), .cmd_hi(chi),
      .cmd_v(cval), .res_valid(rv), .res_ready(pop),
      .res_status(rsp_status), .res_time(rsp_point_time),
      .res_value(rsp_point_value), .res_count(rsp_point_count));

   assign empty = !rv;

   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop && !empty |=> empty) else $error("result not retired after transfer");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty) else $error("waiting result lost");
   a_step: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> step_ff == $past(csr_wdata)) else $error("spacing write lost");
endmodule

[sim/testbench.sv]
// Testbench for the breakpoint envelope table: bit-exact prediction and per-field checks.
`timescale 1ns / 1ps
module testbench;
   import bet_pkg::*;

   localparam int NPTS  = MAX_POINTS_DEF;
   localparam int TBITS = TIME_BITS_DEF;
   localparam int VBITS = VALUE_BITS_DEF;

   typedef struct packed {
      op_type            op;
      logic [TBITS-1:0]  t;
      logic [TBITS-1:0]  hi;
      logic [VBITS-1:0]  v;
   } req_t;

   typedef struct packed {
      logic [1:0]        status;
      logic [TBITS-1:0]  t;
      logic [VBITS-1:0]  v;
      logic [6:0]        count;
   } rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [OP_BITS-1:0]      req_op = '0;
   logic [TBITS-1:0]        req_time_req = '0;
   logic [TBITS-1:0]        req_upper_time = '0;
   logic signed [VBITS-1:0] req_value = '0;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [TBITS-1:0]        rsp_point_time;
   logic signed [VBITS-1:0] rsp_point_value;
   logic [COUNT_BITS-1:0]   rsp_point_count;
   logic                    csr_we = 1'b0;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   breakpoint_envelope_table_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_op(req_op), .req_time_req(req_time_req), .req_upper_time(req_upper_time),
      .req_value(req_value), .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_point_time(rsp_point_time),
      .rsp_point_value(rsp_point_value), .rsp_point_count(rsp_point_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Shadow table used to predict every result.
   longint unsigned  tab_t[NPTS];
   longint           tab_v[NPTS];
   int               tab_n = 0;
   longint unsigned  spacing = 0;

   req_t   pending_reqs[$];
   rsp_t   expected_rsps[$];
   int     failures = 0;
   int     send_idle_pct = 0;   // chance per cycle that the sender holds back
   int     recv_stall_pct = 0;  // chance per cycle that the receiver stalls
   int     hold_off = 0;        // long receiver hold-off, counted down in cycles
   bit     took_req = 1'b0;

   function automatic longint unsigned tgap(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Squeeze out entries: spacing mode uses distance to pt, else open range (lo, hi).
   function automatic void table_squeeze(bit by_spacing, longint unsigned pt,
                                         longint unsigned lo, longint unsigned hi);
      int k;
      bit drop;
      k = 0;
      for (int i = 0; i < tab_n; i++) begin
         drop = by_spacing ? (tgap(tab_t[i], pt) < spacing)
                           : (tab_t[i] > lo && tab_t[i] < hi);
         if (!drop) begin
            tab_t[k] = tab_t[i];
            tab_v[k] = tab_v[i];
            k++;
         end
      end
      tab_n = k;
   endfunction

   function automatic int first_later(longint unsigned t);
      for (int i = 0; i < tab_n; i++)
         if (tab_t[i] > t) return i;
      return -1;
   endfunction

   function automatic int last_earlier(longint unsigned t);
      for (int i = tab_n - 1; i >= 0; i--)
         if (tab_t[i] < t) return i;
      return -1;
   endfunction

   function automatic rsp_t envelope_apply(req_t r);
      rsp_t o;
      longint unsigned t, lt, ut, mag, q;
      longint v, lv, uv, d, res;
      int a, b, pos, best;
      o = '0;
      t = r.t;
      v = longint'(signed'(r.v));
      res = 0;
      case (r.op)
         OP_INSERT: begin
            table_squeeze(1'b1, t, 0, 0);
            if (tab_n >= NPTS) o.status = ST_FULL;
            else begin
               pos = 0;
               while (pos < tab_n && tab_t[pos] <= t) pos++;
               for (int i = tab_n; i > pos; i--) begin
                  tab_t[i] = tab_t[i-1];
                  tab_v[i] = tab_v[i-1];
               end
               tab_t[pos] = t;
               tab_v[pos] = v;
               tab_n++;
            end
         end
         OP_REMOVE: table_squeeze(1'b0, 0, t, r.hi);
         OP_VALUE: begin
            a = last_earlier(t);
            b = first_later(t);
            if (a < 0 || b < 0) o.status = ST_NONE;
            else begin
               lt = tab_t[a]; ut = tab_t[b];
               lv = tab_v[a]; uv = tab_v[b];
               d = uv - lv;
               mag = (d < 0) ? -d : d;
               // 25-bit magnitude times 24-bit span fits 64 bits
               q = (mag * (t - lt)) / (ut - lt);
               res = (d < 0) ? lv - longint'(q) : lv + longint'(q);
            end
         end
         OP_NEAR: begin
            if (tab_n == 0) o.status = ST_NONE;
            else begin
               best = 0;
               for (int i = 1; i < tab_n; i++)
                  if (tgap(tab_t[i], t) < tgap(tab_t[best], t)) best = i;
               o.t = tab_t[best][TBITS-1:0];
               res = tab_v[best];
            end
         end
         OP_AFTER, OP_BEFORE: begin
            a = (r.op == OP_AFTER) ? first_later(t) : last_earlier(t);
            if (a < 0) o.status = ST_NONE;
            else begin
               o.t = tab_t[a][TBITS-1:0];
               res = tab_v[a];
            end
         end
         default: o.status = ST_NONE;
      endcase
      o.v = res[VBITS-1:0];
      o.count = tab_n[6:0];
      return o;
   endfunction

   // Long receiver hold-off, counted down once per cycle.
   always @(negedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   // Driver: one request offered per cycle when not idling and full is low; changes on the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!push || took_req) begin
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_op         <= pending_reqs[0].op;
               req_time_req   <= pending_reqs[0].t;
               req_upper_time <= pending_reqs[0].hi;
               req_value      <= pending_reqs[0].v;
               push           <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
         if (hold_off > 0) pop <= 1'b0;
         else pop <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // Monitor: sample both channels on the rising edge.
   always @(posedge clock) begin
      rsp_t got, want;
      took_req <= !reset && push && !full;
      if (!reset) begin
         if (push && !full)
            expected_rsps = {expected_rsps, envelope_apply(pending_reqs.pop_front())};
         if (pop && !empty) begin
            got = {rsp_status, rsp_point_time, rsp_point_value, rsp_point_count};
            if (expected_rsps.size() == 0) begin
               $error("result with nothing expected");
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  failures++;
               end
               if (got.t !== want.t) begin
                  $error("point_time: expected %0d, got %0d", want.t, got.t);
                  failures++;
               end
               if (got.v !== want.v) begin
                  $error("point_value: expected %0d, got %0d",
                         signed'(want.v), signed'(got.v));
                  failures++;
               end
               if (got.count !== want.count) begin
                  $error("point_count: expected %0d, got %0d", want.count, got.count);
                  failures++;
               end
            end
         end
      end
   end

   function automatic req_t make_req(op_type op, int unsigned t, int unsigned hi,
                                     int unsigned v);
      req_t r;
      r.op = op; r.t = t[TBITS-1:0]; r.hi = hi[TBITS-1:0]; r.v = v[VBITS-1:0];
      return r;
   endfunction

   task automatic add_req(req_t r);
      pending_reqs = {pending_reqs, r};
   endtask

   // Times cluster in a narrow window most of the time so searches hit.
   function automatic int unsigned pick_time();
      case ($urandom_range(9, 0))
         0: return $urandom_range(24'hFFFFFF, 0);
         1: return $urandom_range(3, 0);
         2: return $urandom_range(24'hFFFFFF, 24'hFFFFFC);
         default: return $urandom_range(4095, 0);
      endcase
   endfunction

   function automatic req_t random_req();
      int unsigned t, sel;
      op_type op;
      sel = $urandom_range(99, 0);
      op = (sel < 45) ? OP_INSERT : (sel < 52) ? OP_REMOVE : (sel < 70) ? OP_VALUE :
           (sel < 80) ? OP_NEAR : (sel < 88) ? OP_AFTER : (sel < 96) ? OP_BEFORE :
           (sel < 98) ? OP_BAD6 : OP_BAD7;
      t = pick_time();
      return make_req(op, t, (op == OP_REMOVE) ? t + $urandom_range(300, 0) : pick_time(),
                      $urandom());
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic set_spacing(int unsigned s);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= s[CSR_BITS-1:0];
      spacing = s;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, equal times, table full, odd op codes.
      set_spacing(0);
      add_req(make_req(OP_NEAR, 5, 0, 0));
      add_req(make_req(OP_VALUE, 5, 0, 0));
      add_req(make_req(OP_INSERT, 100, 0, 24'h7FFFFF));
      add_req(make_req(OP_INSERT, 100, 0, 24'h800000));
      add_req(make_req(OP_INSERT, 0, 0, 24'h000001));
      add_req(make_req(OP_INSERT, 24'hFFFFFF, 0, 24'hFFFFFF));
      add_req(make_req(OP_VALUE, 50, 0, 0));
      add_req(make_req(OP_VALUE, 24'h800000, 0, 0));
      add_req(make_req(OP_VALUE, 100, 0, 0));
      add_req(make_req(OP_NEAR, 50, 0, 0));
      add_req(make_req(OP_AFTER, 100, 0, 0));
      add_req(make_req(OP_BEFORE, 100, 0, 0));
      add_req(make_req(OP_AFTER, 24'hFFFFFF, 0, 0));
      add_req(make_req(OP_BEFORE, 0, 0, 0));
      add_req(make_req(OP_BAD6, 1, 2, 3));
      add_req(make_req(OP_BAD7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      add_req(make_req(OP_REMOVE, 100, 100, 0));
      add_req(make_req(OP_REMOVE, 0, 24'hFFFFFF, 0));
      for (int i = 0; i < 66; i++)
         add_req(make_req(OP_INSERT, i * 7, 0, $urandom()));
      add_req(make_req(OP_REMOVE, 0, 24'hFFFFFF, 0));
      drain();

      // Random phases: spacing and idling vary; one phase has a long hold-off.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_spacing(24'hFFFFFF);
            1: set_spacing(3);
            2: set_spacing(0);
            default: set_spacing($urandom_range(40, 0));
         endcase
         send_idle_pct  = (ph == 2 || ph == 5) ? 83 : (ph == 4) ? 7 : 0;
         recv_stall_pct = (ph == 3 || ph == 5) ? 83 : (ph == 4) ? 7 : 0;
         if (ph == 1) hold_off = 2000;
         for (int i = 0; i < 180; i++) add_req(random_req());
         drain();
      end

      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("testbench NOT OK");
      $finish;
   end
endmodule
